/* src/dtds_pkg.sv */
package dtds_pkg;

    // Fixed field widths of the request and descriptor streams
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned BYTES_W = 26;
    localparam int unsigned SLOT_W  = 7;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned PAY_W   = 20;
    localparam int unsigned COUNT_W = 7;   // descriptor count, 1 to 64

    // Request queue between the classifier and the sequencer
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    // Classified request: start addresses, descriptor count, last payload
    typedef struct packed {
        logic [ADDR_W-1:0]  dst;
        logic [ADDR_W-1:0]  src;
        logic [COUNT_W-1:0] count;
        logic [PAY_W-1:0]   last_bytes;
    } cmd_t;

    // One descriptor as it leaves the sequencer
    typedef struct packed {
        logic               last;
        logic [PAY_W-1:0]   bytes;
        logic [ADDR_W-1:0]  dst;
        logic [ADDR_W-1:0]  src;
        logic [INDEX_W-1:0] index;
        logic [SLOT_W-1:0]  slot;
    } desc_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } back_state_t;

endpackage

/* src/dtds_front.sv */
module dtds_front #(
    parameter int unsigned CHUNK_SHIFT = 19,
    parameter int unsigned MAX_DESCS   = 64
) (
    input  logic [dtds_pkg::ADDR_W-1:0]  dest_address,
    input  logic [dtds_pkg::ADDR_W-1:0]  source_address,
    input  logic [dtds_pkg::BYTES_W-1:0] byte_count,
    output dtds_pkg::cmd_t               cmd
);

    localparam int unsigned SUM_W = dtds_pkg::BYTES_W + 1;
    localparam logic [SUM_W-1:0] CHUNK = SUM_W'(1) << CHUNK_SHIFT;
    localparam logic [SUM_W-1:0] CHUNK_MASK = CHUNK - SUM_W'(1);

    logic [SUM_W-1:0] round_up;
    logic [SUM_W-1:0] count_raw;
    logic [SUM_W-1:0] rem;
    logic             rem_zero;

    // Chunk count rounded up, and the remainder of the last chunk
    always_comb
    begin
        round_up  = {1'b0, byte_count} + CHUNK_MASK;
        count_raw = round_up >> CHUNK_SHIFT;
        rem       = {1'b0, byte_count} & CHUNK_MASK;
        rem_zero  = (rem == '0);
    end

    // Classify: empty request is one full chunk, oversized is clipped
    always_comb
    begin
        cmd.dst = dest_address;
        cmd.src = source_address;
        priority if (count_raw > SUM_W'(MAX_DESCS))
        begin
            cmd.count      = dtds_pkg::COUNT_W'(MAX_DESCS);
            cmd.last_bytes = CHUNK[dtds_pkg::PAY_W-1:0];
        end
        else if (count_raw == '0)
        begin
            cmd.count      = dtds_pkg::COUNT_W'(1);
            cmd.last_bytes = CHUNK[dtds_pkg::PAY_W-1:0];
        end
        else
        begin
            cmd.count      = count_raw[dtds_pkg::COUNT_W-1:0];
            cmd.last_bytes = rem_zero ? CHUNK[dtds_pkg::PAY_W-1:0]
                                      : rem[dtds_pkg::PAY_W-1:0];
        end
    end

endmodule

/* src/dtds_fifo.sv */
module dtds_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dtds_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output dtds_pkg::cmd_t out_cmd
);

    dtds_pkg::cmd_t                    entry_reg [dtds_pkg::QDEPTH];
    logic [dtds_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [dtds_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [dtds_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                              push, pop;

    assign in_ready  = (cnt_reg != dtds_pkg::QCNT_W'(dtds_pkg::QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + dtds_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + dtds_pkg::QPTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + dtds_pkg::QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - dtds_pkg::QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* src/dtds_back.sv */
module dtds_back #(
    parameter int unsigned CHUNK_SHIFT = 19,
    parameter int unsigned RING_SLOTS  = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  dtds_pkg::cmd_t  cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output dtds_pkg::desc_t out_desc
);

    localparam int unsigned TAIL_W = $clog2(RING_SLOTS + 1);
    localparam logic [dtds_pkg::ADDR_W-1:0] CHUNK =
        dtds_pkg::ADDR_W'(1) << CHUNK_SHIFT;

    dtds_pkg::back_state_t           state_reg, state_next;
    logic [TAIL_W-1:0]               tail_reg, tail_next;
    logic [dtds_pkg::COUNT_W-1:0]    left_reg, left_next;
    logic [dtds_pkg::ADDR_W-1:0]     src_reg, src_next;
    logic [dtds_pkg::ADDR_W-1:0]     dst_reg, dst_next;
    logic [dtds_pkg::PAY_W-1:0]      last_bytes_reg, last_bytes_next;
    logic                            out_valid_reg, out_valid_next;
    dtds_pkg::desc_t                 desc_reg, desc_next;
    logic                            load, emit, final_one;
    logic [31:0]                     tail_ext, tail_m1;

    assign cmd_ready = (state_reg == dtds_pkg::S_IDLE);
    assign load      = cmd_valid && cmd_ready;
    assign emit      = (state_reg == dtds_pkg::S_RUN) && (!out_valid_reg || out_ready);
    assign final_one = (left_reg == dtds_pkg::COUNT_W'(1));
    assign tail_ext  = 32'(tail_reg);
    assign tail_m1   = tail_ext - 32'd1;
    assign out_valid = out_valid_reg;
    assign out_desc  = desc_reg;

    // Sequencer: load a request, then one descriptor per free output slot
    always_comb
    begin
        state_next      = state_reg;
        left_next       = left_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        last_bytes_next = last_bytes_reg;
        tail_next       = tail_reg;
        desc_next       = desc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            dtds_pkg::S_IDLE:
            begin
                if (load)
                begin
                    state_next      = dtds_pkg::S_RUN;
                    left_next       = cmd.count;
                    src_next        = cmd.src;
                    dst_next        = cmd.dst;
                    last_bytes_next = cmd.last_bytes;
                end
            end
            dtds_pkg::S_RUN:
            begin
                if (emit)
                begin
                    desc_next.slot  = tail_m1[dtds_pkg::SLOT_W-1:0];
                    desc_next.index = tail_ext[dtds_pkg::INDEX_W-1:0];
                    desc_next.src   = src_reg;
                    desc_next.dst   = dst_reg;
                    desc_next.bytes = final_one ? last_bytes_reg
                                                : CHUNK[dtds_pkg::PAY_W-1:0];
                    desc_next.last  = final_one;
                    out_valid_next  = 1'b1;
                    src_next        = src_reg + CHUNK;
                    dst_next        = dst_reg + CHUNK;
                    left_next       = left_reg - dtds_pkg::COUNT_W'(1);
                    // tail runs 1..RING_SLOTS and wraps back to 1
                    if (tail_reg >= TAIL_W'(RING_SLOTS) || tail_reg == '0)
                    begin
                        tail_next = TAIL_W'(1);
                    end
                    else
                    begin
                        tail_next = tail_reg + TAIL_W'(1);
                    end
                    if (final_one)
                    begin
                        state_next = dtds_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dtds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtds_pkg::S_IDLE;
            tail_reg      <= TAIL_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working copy of the request and the output register
    always_ff @(posedge clk)
    begin
        left_reg       <= left_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        last_bytes_reg <= last_bytes_next;
        desc_reg       <= desc_next;
    end

endmodule

/* src/dma_transfer_descriptor_splitter.sv */
// Copy-request splitter. Each request on the slave stream (destination,
// source, byte count) is cut into descriptors of at most 2^CHUNK_SHIFT bytes
// on the master stream; both addresses advance by one chunk per descriptor,
// the last descriptor carries the remainder (a full chunk when it is zero,
// so an empty request gives one full descriptor) and raises tlast. Requests
// needing more than MAX_DESCS chunks are clipped to MAX_DESCS full chunks.
// Each descriptor gets the ring tail index (1..RING_SLOTS, wrapping to 1) and
// the slot index-1. A classifier feeds a two-entry request queue; the
// sequencer behind it loads a request and then emits one descriptor per
// cycle while the master stream accepts them. It takes no new request
// until the last one is out; up to two further requests wait in the queue.
module dma_transfer_descriptor_splitter #(
    parameter int unsigned CHUNK_SHIFT = 19,
    parameter int unsigned RING_SLOTS  = 128,
    parameter int unsigned MAX_DESCS   = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] dest_address, [127:64] source_address, [153:128] byte_count
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [6:0] ring_slot, [14:7] desc_index, [78:15] chunk_source,
    // [142:79] chunk_dest, [162:143] payload_bytes
    output logic [167:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam logic [dtds_pkg::ADDR_W-1:0] CHUNK =
        dtds_pkg::ADDR_W'(1) << CHUNK_SHIFT;

    dtds_pkg::cmd_t  front_cmd;
    dtds_pkg::cmd_t  queue_cmd;
    dtds_pkg::desc_t out_desc;
    logic            queue_valid;
    logic            queue_ready;

    // Request classification
    dtds_front #(
        .CHUNK_SHIFT (CHUNK_SHIFT),
        .MAX_DESCS   (MAX_DESCS)
    ) u_front (
        .dest_address   (s_axis_tdata[63:0]),
        .source_address (s_axis_tdata[127:64]),
        .byte_count     (s_axis_tdata[153:128]),
        .cmd            (front_cmd)
    );

    // Request queue
    dtds_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    // Descriptor sequencer
    dtds_back #(
        .CHUNK_SHIFT (CHUNK_SHIFT),
        .RING_SLOTS  (RING_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_desc  (out_desc)
    );

    assign m_axis_tdata = {5'b0, out_desc.bytes, out_desc.dst, out_desc.src,
                           out_desc.index, out_desc.slot};
    assign m_axis_tlast = out_desc.last;

    // Slot is always one below the index
    a_slot_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_desc.index[dtds_pkg::SLOT_W-1:0] ==
                           out_desc.slot + dtds_pkg::SLOT_W'(1)))
        else $error("ring slot does not match descriptor index");

    // Only the last descriptor may carry a short payload
    a_full_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_desc.last) |->
            (out_desc.bytes == CHUNK[dtds_pkg::PAY_W-1:0]))
        else $error("non-final descriptor without a full chunk");

    // A taken non-final descriptor is followed at once by the next chunk
    a_next_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !out_desc.last) |=>
            (m_axis_tvalid && out_desc.src == $past(out_desc.src) + CHUNK &&
             out_desc.dst == $past(out_desc.dst) + CHUNK))
        else $error("descriptor addresses did not advance by one chunk");

endmodule
